// ===== rtl/tllc_pkg.sv =====
`default_nettype none
package tllc_pkg;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        ST_CLEAR  = 3'b001,
        ST_IDLE   = 3'b010,
        ST_LOOKUP = 3'b100
    } t_state;

    // Hit level codes
    localparam logic [1:0] LVL_L1   = 2'd0;
    localparam logic [1:0] LVL_L2   = 2'd1;
    localparam logic [1:0] LVL_MISS = 2'd2;

    // Access codes
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_STORE = 1'b1;

    // Age given to the way written last in an L2 set
    localparam logic [1:0] AGE_NEWEST = 2'd3;

endpackage
`default_nettype wire

// ===== rtl/two_level_lru_cache.sv =====
// An access is accepted in IDLE and looked up in LOOKUP, where its result is registered.
// The set rows are read in the accept cycle and written back in the lookup cycle, and the
// next access waits for that write, so a new access is not taken before the last is done.
// Reset: synchronous, active low. After reset a clearing pass writes every set row,
// during which no access is accepted.
`default_nettype none
module two_level_lru_cache #(
    parameter int L1_SETS   = 4096,
    parameter int L2_SETS   = 16384,
    parameter int ADDR_BITS = 32,
    parameter int WORD_BITS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic               i_mode,
    input  wire logic [31:0]        i_address,
    input  wire logic signed [31:0] i_store_data,
    input  wire logic signed [31:0] i_fill_data,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_read_data,
    output logic [1:0]              o_hit_level,
    output logic                    o_memory_write
);

    localparam int L1_IW    = $clog2(L1_SETS);
    localparam int L2_IW    = $clog2(L2_SETS);
    localparam int T1W      = ADDR_BITS - L1_IW;
    localparam int T2W      = ADDR_BITS - L2_IW;
    localparam int CLR_ROWS = (L1_SETS > L2_SETS) ? L1_SETS : L2_SETS;
    localparam int CLR_W    = $clog2(CLR_ROWS);

    typedef struct packed {
        logic                      older;
        logic [1:0]                vld;
        logic [1:0][T1W-1:0]       tag;
        logic [1:0][WORD_BITS-1:0] word;
    } t_l1_row;

    typedef struct packed {
        logic [3:0][1:0]           age;
        logic [3:0]                vld;
        logic [3:0][T2W-1:0]       tag;
        logic [3:0][WORD_BITS-1:0] word;
    } t_l2_row;

    // Set memories
    t_l1_row l1_mem [L1_SETS];
    t_l2_row l2_mem [L2_SETS];
    t_l1_row r_l1_q, l1_wdata;
    t_l2_row r_l2_q, l2_wdata;
    logic    l1_we, l2_we;
    logic [L1_IW-1:0] l1_widx;
    logic [L2_IW-1:0] l2_widx;

    tllc_pkg::t_state r_state, n_state;
    logic [CLR_W-1:0] r_clr, n_clr;

    logic                 r_mode;
    logic [ADDR_BITS-1:0] r_addr;
    logic [WORD_BITS-1:0] r_sdata, r_fdata;

    logic                 r_out_valid, n_out_valid;
    logic [31:0]          r_rdata, n_rdata;
    logic [1:0]           r_level, n_level;
    logic                 r_mwrite, n_mwrite;

    logic                 accept;
    logic [ADDR_BITS-1:0] in_addr;
    logic [63:0]          sdata_x, fdata_x;

    assign in_addr = i_address[ADDR_BITS-1:0];
    assign sdata_x = {32'b0, i_store_data};
    assign fdata_x = {32'b0, i_fill_data};

    // Input handshake
    assign o_stall = !((r_state == tllc_pkg::ST_IDLE) && (!r_out_valid || !i_stall));
    assign accept  = i_valid && !o_stall;

    // Row reads, issued at accept
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_l1_q <= l1_mem[in_addr[L1_IW-1:0]];
            r_l2_q <= l2_mem[in_addr[L2_IW-1:0]];
        end
    end

    // Row writes
    always_ff @(posedge i_clk) begin
        if (l1_we) begin
            l1_mem[l1_widx] <= l1_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (l2_we) begin
            l2_mem[l2_widx] <= l2_wdata;
        end
    end

    // Captured transaction
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode  <= i_mode;
            r_addr  <= in_addr;
            r_sdata <= sdata_x[WORD_BITS-1:0];
            r_fdata <= fdata_x[WORD_BITS-1:0];
        end
    end

    // Lookup and update
    logic [T1W-1:0]       t1;
    logic [T2W-1:0]       t2;
    logic [1:0]           h1;
    logic [3:0]           h2;
    logic                 hw1, fw1;
    logic [1:0]           hw2, vw2, tw2;
    logic                 l1_hit, l2_hit, is_store;
    logic [WORD_BITS-1:0] word_in, rd_word;
    logic [1:0]           old_age, min_age;
    logic [63:0]          rd_x;

    always_comb begin
        t1       = r_addr[ADDR_BITS-1:L1_IW];
        t2       = r_addr[ADDR_BITS-1:L2_IW];
        is_store = (r_mode == tllc_pkg::MODE_STORE);
        for (int w = 0; w < 2; w++) begin
            h1[w] = r_l1_q.vld[w] && (r_l1_q.tag[w] == t1);
        end
        for (int w = 0; w < 4; w++) begin
            h2[w] = r_l2_q.vld[w] && (r_l2_q.tag[w] == t2);
        end
        l1_hit = |h1;
        l2_hit = |h2;
        hw1    = !h1[0];
        priority if (h2[0]) hw2 = 2'd0;
        else if (h2[1])     hw2 = 2'd1;
        else if (h2[2])     hw2 = 2'd2;
        else                hw2 = 2'd3;

        // L1 fill way: way 1 invalid, else way 0 invalid, else the older way
        priority if (!r_l1_q.vld[1]) fw1 = 1'b1;
        else if (!r_l1_q.vld[0])     fw1 = 1'b0;
        else                         fw1 = r_l1_q.older;

        // L2 victim: lowest invalid way, else lowest way of least age
        tw2     = 2'd0;
        min_age = r_l2_q.age[0];
        for (int w = 1; w < 4; w++) begin
            if (r_l2_q.age[w] < min_age) begin
                tw2     = 2'(w);
                min_age = r_l2_q.age[w];
            end
        end
        priority if (!r_l2_q.vld[0]) vw2 = 2'd0;
        else if (!r_l2_q.vld[1])     vw2 = 2'd1;
        else if (!r_l2_q.vld[2])     vw2 = 2'd2;
        else if (!r_l2_q.vld[3])     vw2 = 2'd3;
        else                         vw2 = tw2;

        l1_wdata = r_l1_q;
        l2_wdata = r_l2_q;
        l1_we    = 1'b0;
        l2_we    = 1'b0;
        l1_widx  = r_addr[L1_IW-1:0];
        l2_widx  = r_addr[L2_IW-1:0];
        rd_word  = '0;
        word_in  = is_store ? r_sdata : r_fdata;
        n_level  = tllc_pkg::LVL_MISS;
        old_age  = '0;

        priority if (r_state == tllc_pkg::ST_CLEAR) begin
            l1_we    = 1'b1;
            l2_we    = 1'b1;
            l1_widx  = r_clr[L1_IW-1:0];
            l2_widx  = r_clr[L2_IW-1:0];
            l1_wdata = '0;
            l2_wdata = '0;
        end else if (r_state == tllc_pkg::ST_LOOKUP) begin
            l1_we = 1'b1;
            if (l1_hit) begin
                n_level = tllc_pkg::LVL_L1;
                if (is_store) begin
                    l1_wdata.word[hw1] = r_sdata;
                end else begin
                    rd_word = r_l1_q.word[hw1];
                end
                l1_wdata.older = !hw1;
            end else begin
                if (l2_hit) begin
                    n_level = tllc_pkg::LVL_L2;
                    if (is_store) begin
                        l2_we              = 1'b1;
                        l2_wdata.word[hw2] = r_sdata;
                        old_age            = r_l2_q.age[hw2];
                        for (int w = 0; w < 4; w++) begin
                            if (2'(w) == hw2) begin
                                l2_wdata.age[w] = tllc_pkg::AGE_NEWEST;
                            end else if (r_l2_q.age[w] > old_age) begin
                                l2_wdata.age[w] = r_l2_q.age[w] - 2'd1;
                            end
                        end
                        word_in = r_sdata;
                    end else begin
                        rd_word = r_l2_q.word[hw2];
                        word_in = rd_word;
                    end
                end else begin
                    l2_we              = 1'b1;
                    l2_wdata.tag[vw2]  = t2;
                    l2_wdata.word[vw2] = word_in;
                    l2_wdata.vld[vw2]  = 1'b1;
                    old_age            = r_l2_q.age[vw2];
                    for (int w = 0; w < 4; w++) begin
                        if (2'(w) == vw2) begin
                            l2_wdata.age[w] = tllc_pkg::AGE_NEWEST;
                        end else if (r_l2_q.age[w] > old_age) begin
                            l2_wdata.age[w] = r_l2_q.age[w] - 2'd1;
                        end
                    end
                    if (!is_store) begin
                        rd_word = word_in;
                    end
                end
                // L1 fill
                l1_wdata.tag[fw1]  = t1;
                l1_wdata.word[fw1] = word_in;
                l1_wdata.vld[fw1]  = 1'b1;
                l1_wdata.older     = !fw1;
            end
        end else begin
            l1_we = 1'b0;
        end

        rd_x     = 64'(rd_word);
        n_rdata  = rd_x[31:0];
        n_mwrite = is_store;
    end

    // Control
    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_out_valid = r_out_valid && i_stall;
        unique case (r_state)
            tllc_pkg::ST_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == CLR_W'(CLR_ROWS - 1)) begin
                    n_state = tllc_pkg::ST_IDLE;
                end
            end
            tllc_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = tllc_pkg::ST_LOOKUP;
                end
            end
            tllc_pkg::ST_LOOKUP: begin
                n_state     = tllc_pkg::ST_IDLE;
                n_out_valid = 1'b1;
            end
            default: begin
                n_state = tllc_pkg::ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tllc_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (r_state == tllc_pkg::ST_LOOKUP) begin
            r_rdata  <= n_rdata;
            r_level  <= n_level;
            r_mwrite <= n_mwrite;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_read_data    = r_rdata;
    assign o_hit_level    = r_level;
    assign o_memory_write = r_mwrite;

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
module testbench;

    localparam int L1S = 4096;
    localparam int L2S = 16384;
    localparam int CYCLE_LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic i_mode = tllc_pkg::MODE_LOAD;
    logic [31:0] i_address = '0;
    logic signed [31:0] i_store_data = '0;
    logic signed [31:0] i_fill_data = '0;
    logic o_valid;
    logic i_stall = 1'b0;
    logic signed [31:0] o_read_data;
    logic [1:0] o_hit_level;
    logic o_memory_write;

    two_level_lru_cache dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_mode(i_mode), .i_address(i_address), .i_store_data(i_store_data),
        .i_fill_data(i_fill_data), .o_valid(o_valid), .i_stall(i_stall),
        .o_read_data(o_read_data), .o_hit_level(o_hit_level),
        .o_memory_write(o_memory_write)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    typedef struct packed {
        logic [31:0] rdata;
        logic [1:0]  level;
        logic        mwrite;
    } t_access_result;

    // Shadow copy of both cache levels
    logic [19:0] l1_tag_m [L1S*2];
    logic        l1_vld_m [L1S*2];
    logic [31:0] l1_word_m [L1S*2];
    logic        l1_old_m [L1S];
    logic [17:0] l2_tag_m [L2S*4];
    logic        l2_vld_m [L2S*4];
    logic [31:0] l2_word_m [L2S*4];
    logic [7:0]  l2_age_m [L2S];

    t_access_result pending_q[$];
    int errors = 0;
    int n_sent = 0;
    int n_checked = 0;
    int cycles = 0;
    int rx_burst = 0;
    bit idle_on = 1'b1;
    bit hold_rx = 1'b0;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch #%0d: %s got %0h want %0h", n_checked, what, got, want);
        errors++;
    endtask

    function automatic void l2_refresh(input int s, input int w);
        logic [1:0] old, a;
        logic [7:0] nv;
        nv = '0;
        old = l2_age_m[s][2*w +: 2];
        for (int k = 0; k < 4; k++) begin
            a = l2_age_m[s][2*k +: 2];
            if (k == w) a = tllc_pkg::AGE_NEWEST;
            else if (a > old) a = a - 2'd1;
            nv[2*k +: 2] = a;
        end
        l2_age_m[s] = nv;
    endfunction

    function automatic void l1_put(input int s, input logic [19:0] t, input logic [31:0] d);
        int w;
        if (!l1_vld_m[s*2+1]) w = 1;
        else if (!l1_vld_m[s*2]) w = 0;
        else w = int'(l1_old_m[s]);
        l1_tag_m[s*2+w] = t;
        l1_word_m[s*2+w] = d;
        l1_vld_m[s*2+w] = 1'b1;
        l1_old_m[s] = (w == 0);
    endfunction

    function automatic void l2_put(input int s, input logic [17:0] t, input logic [31:0] d);
        int w;
        w = 4;
        for (int k = 0; k < 4; k++)
            if (w == 4 && !l2_vld_m[s*4+k]) w = k;
        if (w == 4) begin
            w = 0;
            for (int k = 0; k < 4; k++)
                if (l2_age_m[s][2*k +: 2] < l2_age_m[s][2*w +: 2]) w = k;
        end
        l2_tag_m[s*4+w] = t;
        l2_word_m[s*4+w] = d;
        l2_vld_m[s*4+w] = 1'b1;
        l2_refresh(s, w);
    endfunction

    function automatic t_access_result predict_access(input logic md, input logic [31:0] a,
                                                      input logic [31:0] sd,
                                                      input logic [31:0] fd);
        t_access_result r;
        int s1, s2, h1, h2;
        logic [19:0] t1;
        logic [17:0] t2;
        s1 = int'(a % L1S); t1 = 20'(a / L1S);
        s2 = int'(a % L2S); t2 = 18'(a / L2S);
        h1 = 2; h2 = 4;
        r = '0;
        r.mwrite = (md == tllc_pkg::MODE_STORE);
        for (int w = 0; w < 2; w++)
            if (h1 == 2 && l1_vld_m[s1*2+w] && l1_tag_m[s1*2+w] == t1) h1 = w;
        if (h1 == 2)
            for (int w = 0; w < 4; w++)
                if (h2 == 4 && l2_vld_m[s2*4+w] && l2_tag_m[s2*4+w] == t2) h2 = w;
        if (h1 != 2) begin
            r.level = tllc_pkg::LVL_L1;
            if (md == tllc_pkg::MODE_STORE) l1_word_m[s1*2+h1] = sd;
            else r.rdata = l1_word_m[s1*2+h1];
            l1_old_m[s1] = (h1 == 0);
        end else if (h2 != 4) begin
            r.level = tllc_pkg::LVL_L2;
            if (md == tllc_pkg::MODE_STORE) begin
                l2_word_m[s2*4+h2] = sd;
                l2_refresh(s2, h2);
                l1_put(s1, t1, sd);
            end else begin
                r.rdata = l2_word_m[s2*4+h2];
                l1_put(s1, t1, r.rdata);
            end
        end else begin
            r.level = tllc_pkg::LVL_MISS;
            if (md == tllc_pkg::MODE_LOAD) r.rdata = fd;
            l1_put(s1, t1, md == tllc_pkg::MODE_STORE ? sd : fd);
            l2_put(s2, t2, md == tllc_pkg::MODE_STORE ? sd : fd);
        end
        return r;
    endfunction

    // Offer one transaction, with an optional random gap first
    task automatic send_access(input logic md, input logic [31:0] a,
                               input logic [31:0] sd, input logic [31:0] fd);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_mode <= md;
        i_address <= a;
        i_store_data <= sd;
        i_fill_data <= fd;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        pending_q.push_back(predict_access(md, a, sd, fd));
        n_sent++;
        @(negedge i_clk);
    endtask

    // Result checker
    always @(posedge i_clk) begin
        t_access_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            n_checked++;
            if (pending_q.size() == 0) begin
                report("unexpected result", o_read_data, 0);
            end else begin
                e = pending_q.pop_front();
                if (o_read_data !== e.rdata) report("read_data", o_read_data, e.rdata);
                if (o_hit_level !== e.level) report("hit_level", o_hit_level, e.level);
                if (o_memory_write !== e.mwrite)
                    report("memory_write", o_memory_write, e.mwrite);
            end
        end
    end

    // Receiver stall: random bursts, or a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_rx) begin
            i_stall <= 1'b1;
        end else if (rx_burst > 0) begin
            i_stall <= 1'b1;
            rx_burst--;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            i_stall <= 1'b1;
            rx_burst = $urandom_range(0, 5);
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    function automatic logic [31:0] rnd32();
        return $urandom;
    endfunction

    // Addresses from a few sets and tags so that hits and evictions occur
    function automatic logic [31:0] hot_addr();
        logic [31:0] s, t;
        s = $urandom_range(0, 7);
        t = $urandom_range(0, 9);
        return t * L2S + s + ($urandom_range(0, 1) ? L1S : 0);
    endfunction

    task automatic test_directed();
        send_access(tllc_pkg::MODE_LOAD, 32'h0, 32'h0, 32'h1234_5678);
        send_access(tllc_pkg::MODE_LOAD, 32'h0, 32'hFFFF_FFFF, 32'h0);
        send_access(tllc_pkg::MODE_STORE, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_access(tllc_pkg::MODE_LOAD, 32'h0, 32'h0, 32'h0);
        send_access(tllc_pkg::MODE_LOAD, 32'hFFFF_FFFF, 32'h0, 32'h8000_0000);
        send_access(tllc_pkg::MODE_STORE, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        // Evict from L1 set 5 while L2 keeps the line, then hit in L2
        send_access(tllc_pkg::MODE_LOAD, 32'd5, 32'h0, 32'hAAAA_0001);
        send_access(tllc_pkg::MODE_LOAD, 32'd5 + L1S, 32'h0, 32'hAAAA_0002);
        send_access(tllc_pkg::MODE_LOAD, 32'd5 + 2*L1S, 32'h0, 32'hAAAA_0003);
        send_access(tllc_pkg::MODE_LOAD, 32'd5, 32'h0, 32'h0);
        // Stale L2 after an L1 store hit
        send_access(tllc_pkg::MODE_STORE, 32'd5, 32'h5555_5555, 32'h0);
        send_access(tllc_pkg::MODE_LOAD, 32'd5 + 3*L1S, 32'h0, 32'hBBBB_0001);
        send_access(tllc_pkg::MODE_LOAD, 32'd5 + 2*L1S, 32'h0, 32'h0);
        send_access(tllc_pkg::MODE_LOAD, 32'd5, 32'h0, 32'h0);
        // Store hitting L2 only, then fill all four L2 ways and evict
        send_access(tllc_pkg::MODE_STORE, 32'd5 + L1S, 32'hCAFE_F00D, 32'h0);
        for (int k = 1; k <= 5; k++)
            send_access(tllc_pkg::MODE_LOAD, 32'd9 + k*L2S, 32'h0, rnd32());
        send_access(tllc_pkg::MODE_LOAD, 32'd9 + L2S, 32'h0, rnd32());
    endtask

    task automatic test_random(input int count);
        for (int k = 0; k < count; k++)
            send_access($urandom_range(0, 1) ? tllc_pkg::MODE_STORE : tllc_pkg::MODE_LOAD,
                        $urandom_range(0, 3) == 0 ? rnd32() : hot_addr(), rnd32(), rnd32());
    endtask

    task automatic test_backpressure();
        fork
            begin
                hold_rx = 1'b1;
                repeat (60) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            test_random(20);
        join
    endtask

    initial begin
        for (int k = 0; k < L1S*2; k++) l1_vld_m[k] = 1'b0;
        for (int k = 0; k < L1S; k++) l1_old_m[k] = 1'b0;
        for (int k = 0; k < L2S*4; k++) l2_vld_m[k] = 1'b0;
        for (int k = 0; k < L2S; k++) l2_age_m[k] = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(1300);
        test_backpressure();
        test_random(400);
        idle_on = 1'b0;
        test_random(200);
        i_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("%0d accesses sent, %0d results checked (loads, stores, L1/L2 hits, misses,",
                 n_sent, n_checked);
        $display("evictions, stale L2 words, a long receiver hold-off)");
        if (errors == 0 && pending_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
